// ===== design/chm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the chained hash map.
package chm_pkg;

	localparam int KEY_WIDTH = 32;
	localparam int VALUE_WIDTH = 32;
	localparam int CFG_WIDTH = 9;
	localparam int DEF_BUCKETS = 256;
	localparam int DEF_ENTRIES = 256;
	localparam int DIGIT_BITS = 4;
	localparam int KEY_DIGITS = (KEY_WIDTH + DIGIT_BITS - 1) / DIGIT_BITS;

	typedef enum logic [1:0] {
		ACT_PUT = 2'd0,
		ACT_GET = 2'd1,
		ACT_DEL = 2'd2,
		ACT_NOP = 2'd3
	} action_t;

	typedef struct packed {
		action_t                action;
		logic [KEY_WIDTH-1:0]   key;
		logic [VALUE_WIDTH-1:0] value;
	} request_t;

	typedef struct packed {
		logic                   found;
		logic [VALUE_WIDTH-1:0] read_value;
		logic                   status;
	} result_t;

	typedef struct packed {
		logic sweep;
		logic accept;
		logic div_step;
		logic head_read;
		logic load_here;
		logic entry_read;
		logic mark_found;
		logic advance;
		logic apply;
		logic load_result;
	} dp_cmd_t;

	typedef struct packed {
		logic sweep_last;
		logic div_last;
		logic here_nil;
		logic key_match;
		logic out_free;
		logic req_nop;
	} dp_status_t;

endpackage

// ===== design/chained_hash_map.sv =====
`timescale 1ns / 1ps
// Top level of the chained hash map: configuration register, controller and datapath.
//
//  Channel   Valid          Ready / stall    Payload
//  request   request_valid  request_stall    request (action, key, value)
//  result    result_valid   result_stall     result (found, read_value, status)
//  config    config_valid   config_ready     config_data (bucket count)
//
// A request first reduces its key modulo the bucket count and then walks the bucket's
// chain; the modulo unit handles four key bits per cycle and each chain step needs one
// memory read and one compare. A NOP request skips both and goes straight to the result.
// After reset a clearing pass initializes the bucket heads and the free stack; no request
// is taken meanwhile.
// A waiting result stays in the output register while the next request is taken; that
// request holds in its final state until the register is free.
module chained_hash_map #(
	parameter int BUCKETS = chm_pkg::DEF_BUCKETS,
	parameter int ENTRIES = chm_pkg::DEF_ENTRIES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           request_valid,
	output logic                           request_stall,
	input  chm_pkg::request_t              request,
	output logic                           result_valid,
	input  logic                           result_stall,
	output chm_pkg::result_t               result,
	input  logic                           config_valid,
	output logic                           config_ready,
	input  logic [chm_pkg::CFG_WIDTH-1:0]  config_data
);

	localparam int BNW = $clog2(BUCKETS + 1);
	localparam int NW = (BNW > chm_pkg::CFG_WIDTH) ? BNW : chm_pkg::CFG_WIDTH;

	logic [NW-1:0]       bucket_count_q;
	chm_pkg::dp_cmd_t    cmd;
	chm_pkg::dp_status_t st;

	assign config_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bucket_count_q <= NW'(BUCKETS);
		else if (config_valid && config_ready) bucket_count_q <= NW'(config_data);
	end

	chm_ctrl u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.request_valid (request_valid),
		.request_stall (request_stall),
		.st            (st),
		.cmd           (cmd)
	);

	chm_datapath #(
		.BUCKETS (BUCKETS),
		.ENTRIES (ENTRIES),
		.NW      (NW)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.request      (request),
		.bucket_count (bucket_count_q),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

// ===== design/chm_ctrl.sv =====
`timescale 1ns / 1ps
// Controller state machine of the chained hash map.
module chm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                request_valid,
	output logic                request_stall,
	input  chm_pkg::dp_status_t st,
	output chm_pkg::dp_cmd_t    cmd
);

	typedef enum logic [8:0] {
		ST_INIT  = 9'b000000001,
		ST_IDLE  = 9'b000000010,
		ST_DIV   = 9'b000000100,
		ST_HEAD  = 9'b000001000,
		ST_LOAD  = 9'b000010000,
		ST_CHECK = 9'b000100000,
		ST_CMP   = 9'b001000000,
		ST_ACT   = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	assign request_stall = (state_q != ST_IDLE);

	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_INIT: begin
				cmd.sweep = 1'b1;
				if (st.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (request_valid) begin
					cmd.accept = 1'b1;
					state_d = st.req_nop ? ST_DONE : ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (st.div_last) state_d = ST_HEAD;
			end
			ST_HEAD: begin
				cmd.head_read = 1'b1;
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load_here = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (st.here_nil) begin
					state_d = ST_ACT;
				end else begin
					cmd.entry_read = 1'b1;
					state_d = ST_CMP;
				end
			end
			ST_CMP: begin
				if (st.key_match) begin
					cmd.mark_found = 1'b1;
					state_d = ST_ACT;
				end else begin
					cmd.advance = 1'b1;
					state_d = ST_CHECK;
				end
			end
			ST_ACT: begin
				cmd.apply = 1'b1;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (st.out_free) begin
					cmd.load_result = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_INIT;
		else state_q <= state_d;
	end

endmodule

// ===== design/chm_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the chained hash map: modulo unit, table memories and result register.
module chm_datapath #(
	parameter int BUCKETS = chm_pkg::DEF_BUCKETS,
	parameter int ENTRIES = chm_pkg::DEF_ENTRIES,
	parameter int NW = 9
) (
	input  logic                clk,
	input  logic                arst_n,
	input  chm_pkg::dp_cmd_t    cmd,
	output chm_pkg::dp_status_t st,
	input  chm_pkg::request_t   request,
	input  logic [NW-1:0]       bucket_count,
	output logic                result_valid,
	input  logic                result_stall,
	output chm_pkg::result_t    result
);

	localparam int KW = chm_pkg::KEY_WIDTH;
	localparam int VW = chm_pkg::VALUE_WIDTH;
	localparam int DB = chm_pkg::DIGIT_BITS;
	localparam int KD = chm_pkg::KEY_DIGITS;
	localparam int KP = KD * DB;
	localparam int CW = $clog2(KD + 1);
	localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int LW = $clog2(ENTRIES + 1);
	localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
	localparam int MAXD = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
	localparam int SW = (MAXD > 1) ? $clog2(MAXD) : 1;
	localparam logic [LW-1:0] NIL = LW'(ENTRIES);

	logic [LW-1:0] head_mem [BUCKETS];
	logic [IW-1:0] stack_mem [ENTRIES];
	logic [KW-1:0] key_mem [ENTRIES];
	logic [VW-1:0] value_mem [ENTRIES];
	logic [LW-1:0] link_mem [ENTRIES];

	chm_pkg::request_t req_q;
	chm_pkg::result_t  result_q;
	logic              result_valid_q;
	logic [NW-1:0]     n_q;
	logic [KP-1:0]     shift_q;
	logic [NW-1:0]     rem_q;
	logic [CW-1:0]     cnt_q;
	logic [LW-1:0]     head_rd_q;
	logic [IW-1:0]     stack_rd_q;
	logic [LW-1:0]     here_q, prev_q;
	logic [KW-1:0]     key_rd_q;
	logic [VW-1:0]     value_rd_q;
	logic [LW-1:0]     link_rd_q;
	logic              found_q, full_q;
	logic [LW-1:0]     fc_q;
	logic [SW-1:0]     sweep_q;

	logic [NW-1:0] n_d, rem_d;
	logic [NW:0]   trial;
	logic [BW-1:0] bidx;
	logic [IW-1:0] here_idx, prev_idx, push_idx, pop_idx;
	logic [LW-1:0] pop_full;
	logic          sweep_head, sweep_stack;
	logic          is_put, is_del, prev_nil, pool_empty;
	logic          alloc, update, unlink, head_we;
	logic [LW-1:0] head_wd;

	always_comb begin
		if (bucket_count == '0) n_d = NW'(1);
		else if ({1'b0, bucket_count} > (NW + 1)'(BUCKETS)) n_d = NW'(BUCKETS);
		else n_d = bucket_count;
	end

	always_comb begin
		rem_d = rem_q;
		trial = '0;
		for (int i = 0; i < DB; i++) begin
			trial = {rem_d, shift_q[KP-1-i]};
			if (trial >= {1'b0, n_q}) trial = trial - {1'b0, n_q};
			rem_d = trial[NW-1:0];
		end
	end

	assign bidx = rem_q[BW-1:0];
	assign here_idx = here_q[IW-1:0];
	assign prev_idx = prev_q[IW-1:0];
	assign push_idx = fc_q[IW-1:0];
	assign pop_full = fc_q - LW'(1);
	assign pop_idx = pop_full[IW-1:0];
	assign sweep_head = ({1'b0, sweep_q} < (SW + 1)'(BUCKETS));
	assign sweep_stack = ({1'b0, sweep_q} < (SW + 1)'(ENTRIES));

	assign is_put = (req_q.action == chm_pkg::ACT_PUT);
	assign is_del = (req_q.action == chm_pkg::ACT_DEL);
	assign prev_nil = (prev_q >= NIL);
	assign pool_empty = (fc_q == '0);
	assign alloc = cmd.apply && is_put && !found_q && !pool_empty;
	assign update = cmd.apply && is_put && found_q;
	assign unlink = cmd.apply && is_del && found_q;
	assign head_we = alloc || (unlink && prev_nil);
	assign head_wd = alloc ? LW'(stack_rd_q) : link_rd_q;

	assign st.sweep_last = (sweep_q == SW'(MAXD - 1));
	assign st.div_last = (cnt_q == CW'(1));
	assign st.here_nil = (here_q >= NIL);
	assign st.key_match = (key_rd_q == req_q.key);
	assign st.out_free = !result_valid_q || !result_stall;
	assign st.req_nop = (request.action == chm_pkg::ACT_NOP);

	always_ff @(posedge clk) begin
		if (cmd.sweep && sweep_head) head_mem[sweep_q[BW-1:0]] <= NIL;
		else if (head_we) head_mem[bidx] <= head_wd;
		if (cmd.head_read) head_rd_q <= head_mem[bidx];
	end

	always_ff @(posedge clk) begin
		if (cmd.sweep && sweep_stack) begin
			stack_mem[sweep_q[IW-1:0]] <= IW'(ENTRIES - 1) - sweep_q[IW-1:0];
		end else if (unlink) begin
			stack_mem[push_idx] <= here_idx;
		end
		if (cmd.accept) stack_rd_q <= stack_mem[pop_idx];
	end

	always_ff @(posedge clk) begin
		if (alloc) key_mem[stack_rd_q] <= req_q.key;
		if (alloc) value_mem[stack_rd_q] <= req_q.value;
		else if (update) value_mem[here_idx] <= req_q.value;
		if (alloc) link_mem[stack_rd_q] <= head_rd_q;
		else if (unlink && !prev_nil) link_mem[prev_idx] <= link_rd_q;
		if (cmd.entry_read) begin
			key_rd_q <= key_mem[here_idx];
			value_rd_q <= value_mem[here_idx];
			link_rd_q <= link_mem[here_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= request;
			n_q <= n_d;
			shift_q <= KP'(request.key);
			rem_q <= '0;
		end else if (cmd.div_step) begin
			shift_q <= shift_q << DB;
			rem_q <= rem_d;
		end
		if (cmd.load_here) begin
			here_q <= head_rd_q;
			prev_q <= NIL;
		end else if (cmd.advance) begin
			here_q <= link_rd_q;
			prev_q <= here_q;
		end
		if (cmd.load_result) begin
			result_q.found <= found_q;
			result_q.read_value <= (found_q && req_q.action == chm_pkg::ACT_GET) ?
				value_rd_q : '0;
			result_q.status <= full_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			found_q <= 1'b0;
			full_q <= 1'b0;
			fc_q <= LW'(ENTRIES);
			sweep_q <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.sweep) sweep_q <= sweep_q + SW'(1);
			if (cmd.accept) cnt_q <= CW'(KD);
			else if (cmd.div_step) cnt_q <= cnt_q - CW'(1);
			if (cmd.accept) found_q <= 1'b0;
			else if (cmd.mark_found) found_q <= 1'b1;
			if (cmd.accept) full_q <= 1'b0;
			else if (cmd.apply) full_q <= is_put && !found_q && pool_empty;
			if (alloc) fc_q <= fc_q - LW'(1);
			else if (unlink) fc_q <= fc_q + LW'(1);
			if (cmd.load_result) result_valid_q <= 1'b1;
			else if (!result_stall) result_valid_q <= 1'b0;
		end
	end

	assign result_valid = result_valid_q;
	assign result = result_q;

endmodule
